FILE: hdl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
// No dependencies; imported by ffba_engine, first_fit_block_allocator and the testbench.
package ffba_pkg;

    localparam int FIELD_W          = 13;
    localparam int DEF_HEAP_BYTES   = 4096;
    localparam int DEF_HEADER_BYTES = 16;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NO_FIT   = 2'd1;
    localparam status_t ST_BAD_FREE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // One command as taken from the input channel
    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] request_bytes;
        logic [FIELD_W-1:0] free_offset;
    } req_t;

    // One answer handed to the output stage
    typedef struct packed {
        logic [FIELD_W-1:0] data_offset;
        status_t            status;
    } res_t;

endpackage

FILE: hdl/ffba_engine.sv
// List-walking sequencer of the allocator with the block header memory.
// Depends on ffba_pkg.
module ffba_engine
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  req_t               req,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_data,
    output logic               idle,
    output logic               res_valid,
    output res_t               res,
    input  logic               res_ready
);

    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int IW = $clog2(HEAP_BYTES);
    localparam int EW = 2 * AW;
    localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 2;

    localparam logic [AW-1:0] NIL = AW'(HEAP_BYTES);
    localparam logic [CW-1:0] HDR = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] TOP = CW'(HEAP_BYTES);
    localparam logic [AW-1:0] RST_SIZE =
        AW'(((HEAP_BYTES < DEF_HEAP_BYTES) ? HEAP_BYTES : DEF_HEAP_BYTES) - HEADER_BYTES);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_A_CHK    = 4'd2;
    localparam logic [3:0] S_A_LINK   = 4'd3;
    localparam logic [3:0] S_INS_TEST = 4'd4;
    localparam logic [3:0] S_INS_RD   = 4'd5;
    localparam logic [3:0] S_INS_LINK = 4'd6;
    localparam logic [3:0] S_F_TEST   = 4'd7;
    localparam logic [3:0] S_F_ADV    = 4'd8;
    localparam logic [3:0] S_F_FOUND  = 4'd9;
    localparam logic [3:0] S_F_MRG_B  = 4'd10;
    localparam logic [3:0] S_F_MRG_N  = 4'd11;
    localparam logic [3:0] S_F_MRG_W  = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    // Header memory: {size, next} per byte offset
    logic [EW-1:0] hdr_mem [HEAP_BYTES];
    logic [EW-1:0] rdata;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [3:0]         state_reg,     state_next;
    logic [AW-1:0]      free_head_reg, free_head_next;
    logic [AW-1:0]      used_head_reg, used_head_next;
    logic [AW-1:0]      init_size_reg, init_size_next;
    logic               cmd_reg,       cmd_next;
    logic [FIELD_W-1:0] rq_reg,        rq_next;
    logic [FIELD_W-1:0] ptr_reg,       ptr_next;
    logic [AW-1:0]      walk_reg,      walk_next;
    logic [AW-1:0]      prev_reg,      prev_next;
    logic [AW-1:0]      psize_reg,     psize_next;
    logic [AW-1:0]      blk_reg,       blk_next;
    logic [AW-1:0]      bsize_reg,     bsize_next;
    logic [AW-1:0]      link_reg,      link_next;
    logic [AW-1:0]      steps_reg,     steps_next;
    res_t               res_reg,       res_next;

    logic [AW-1:0] rd_size;
    logic [AW-1:0] rd_next;
    logic [CW-1:0] sz_w;
    logic [CW-1:0] rq_w;
    logic [CW-1:0] walk_hdr;
    logic [CW-1:0] cfg_w;
    logic [CW-1:0] cfg_clamp;
    logic [AW-1:0] steps_inc;
    logic [AW-1:0] merged_b;

    assign rd_size   = rdata[EW-1:AW];
    assign rd_next   = rdata[AW-1:0];
    assign sz_w      = CW'(rd_size);
    assign rq_w      = CW'(rq_reg);
    assign walk_hdr  = CW'(walk_reg) + HDR;
    assign cfg_w     = CW'(cfg_data);
    assign steps_inc = steps_reg + AW'(1);
    assign merged_b  = AW'(CW'(psize_reg) + HDR + CW'(bsize_reg));

    // Clamp the written heap size into the legal range
    always_comb begin
        if (cfg_w < HDR) begin
            cfg_clamp = HDR;
        end else if (cfg_w > TOP) begin
            cfg_clamp = TOP;
        end else begin
            cfg_clamp = cfg_w;
        end
    end

    // Single-port style header memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr[IW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rdata <= hdr_mem[rd_addr[IW-1:0]];
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        used_head_next = used_head_reg;
        init_size_next = init_size_reg;
        cmd_next       = cmd_reg;
        rq_next        = rq_reg;
        ptr_next       = ptr_reg;
        walk_next      = walk_reg;
        prev_next      = prev_reg;
        psize_next     = psize_reg;
        blk_next       = blk_reg;
        bsize_next     = bsize_reg;
        link_next      = link_reg;
        steps_next     = steps_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = walk_reg;
        wr_en          = 1'b0;
        wr_addr        = blk_reg;
        wr_data        = {bsize_reg, walk_reg};

        unique case (state_reg)
            S_INIT: begin
                // one free block spanning the heap
                wr_en          = 1'b1;
                wr_addr        = '0;
                wr_data        = {init_size_reg, NIL};
                free_head_next = '0;
                used_head_next = NIL;
                state_next     = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_we) begin
                    init_size_next = AW'(cfg_clamp - HDR);
                    state_next     = S_INIT;
                end else if (start) begin
                    cmd_next   = req.cmd;
                    rq_next    = req.request_bytes;
                    ptr_next   = req.free_offset;
                    prev_next  = NIL;
                    steps_next = '0;
                    if (req.cmd == CMD_ALLOC) begin
                        walk_next = free_head_reg;
                        if (free_head_reg >= NIL) begin
                            res_next   = '{data_offset: '0, status: ST_NO_FIT};
                            state_next = S_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = free_head_reg;
                            state_next = S_A_CHK;
                        end
                    end else begin
                        walk_next = used_head_reg;
                        if (req.free_offset == '0) begin
                            res_next   = '{data_offset: '0, status: ST_BAD_FREE};
                            state_next = S_DONE;
                        end else begin
                            state_next = S_F_TEST;
                        end
                    end
                end
            end
            S_A_CHK: begin
                if (sz_w >= rq_w) begin
                    blk_next = walk_reg;
                    if (sz_w >= rq_w + HDR) begin
                        // split off the tail as a new free block
                        link_next  = AW'(CW'(walk_reg) + HDR + rq_w);
                        wr_en      = 1'b1;
                        wr_addr    = AW'(CW'(walk_reg) + HDR + rq_w);
                        wr_data    = {AW'(sz_w - HDR - rq_w), rd_next};
                        bsize_next = AW'(rq_w);
                    end else begin
                        link_next  = rd_next;
                        bsize_next = rd_size;
                    end
                    state_next = S_A_LINK;
                end else begin
                    // advance along the free list
                    prev_next  = walk_reg;
                    psize_next = rd_size;
                    walk_next  = rd_next;
                    steps_next = steps_inc;
                    if (rd_next >= NIL || steps_inc == NIL) begin
                        res_next   = '{data_offset: '0, status: ST_NO_FIT};
                        state_next = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = rd_next;
                    end
                end
            end
            S_A_LINK: begin
                // unlink the taken block, then insert it into the in-use list
                if (prev_reg == NIL) begin
                    free_head_next = link_reg;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg;
                    wr_data = {psize_reg, link_reg};
                end
                prev_next  = NIL;
                walk_next  = used_head_reg;
                steps_next = '0;
                state_next = S_INS_TEST;
            end
            S_INS_TEST: begin
                if (walk_reg < NIL && walk_reg <= blk_reg && steps_reg < NIL) begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_reg;
                    state_next = S_INS_RD;
                end else begin
                    wr_en      = 1'b1;
                    wr_addr    = blk_reg;
                    wr_data    = {bsize_reg, walk_reg};
                    state_next = S_INS_LINK;
                end
            end
            S_INS_RD: begin
                prev_next  = walk_reg;
                psize_next = rd_size;
                walk_next  = rd_next;
                steps_next = steps_inc;
                state_next = S_INS_TEST;
            end
            S_INS_LINK: begin
                if (prev_reg == NIL) begin
                    if (cmd_reg == CMD_ALLOC) begin
                        used_head_next = blk_reg;
                    end else begin
                        free_head_next = blk_reg;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg;
                    wr_data = {psize_reg, blk_reg};
                end
                if (cmd_reg == CMD_ALLOC) begin
                    res_next   = '{data_offset: FIELD_W'(CW'(blk_reg) + HDR), status: ST_OK};
                    state_next = S_DONE;
                end else begin
                    state_next = S_F_MRG_B;
                end
            end
            S_F_TEST: begin
                if (walk_reg >= NIL || steps_reg >= NIL || walk_hdr > CW'(ptr_reg)) begin
                    res_next   = '{data_offset: '0, status: ST_BAD_FREE};
                    state_next = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = walk_reg;
                    if (walk_hdr == CW'(ptr_reg)) begin
                        state_next = S_F_FOUND;
                    end else begin
                        state_next = S_F_ADV;
                    end
                end
            end
            S_F_ADV: begin
                prev_next  = walk_reg;
                psize_next = rd_size;
                walk_next  = rd_next;
                steps_next = steps_inc;
                state_next = S_F_TEST;
            end
            S_F_FOUND: begin
                // drop the block from the in-use list
                blk_next   = walk_reg;
                bsize_next = rd_size;
                if (prev_reg == NIL) begin
                    used_head_next = rd_next;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = prev_reg;
                    wr_data = {psize_reg, rd_next};
                end
                prev_next  = NIL;
                walk_next  = free_head_reg;
                steps_next = '0;
                state_next = S_INS_TEST;
            end
            S_F_MRG_B: begin
                // merge into the free block just below
                if (prev_reg != NIL &&
                    CW'(prev_reg) + HDR + CW'(psize_reg) == CW'(blk_reg)) begin
                    wr_en      = 1'b1;
                    wr_addr    = prev_reg;
                    wr_data    = {merged_b, walk_reg};
                    blk_next   = prev_reg;
                    bsize_next = merged_b;
                end
                state_next = S_F_MRG_N;
            end
            S_F_MRG_N: begin
                if (walk_reg < NIL &&
                    CW'(blk_reg) + HDR + CW'(bsize_reg) == CW'(walk_reg)) begin
                    rd_en      = 1'b1;
                    rd_addr    = walk_reg;
                    state_next = S_F_MRG_W;
                end else begin
                    res_next   = '{data_offset: '0, status: ST_OK};
                    state_next = S_DONE;
                end
            end
            S_F_MRG_W: begin
                // absorb the free block just above
                wr_en      = 1'b1;
                wr_addr    = blk_reg;
                wr_data    = {AW'(CW'(bsize_reg) + HDR + sz_w), rd_next};
                res_next   = '{data_offset: '0, status: ST_OK};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            free_head_reg <= '0;
            used_head_reg <= NIL;
            init_size_reg <= RST_SIZE;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            init_size_reg <= init_size_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        rq_reg    <= rq_next;
        ptr_reg   <= ptr_next;
        walk_reg  <= walk_next;
        prev_reg  <= prev_next;
        psize_reg <= psize_next;
        blk_reg   <= blk_next;
        bsize_reg <= bsize_next;
        link_reg  <= link_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

FILE: hdl/first_fit_block_allocator.sv
// First-fit heap allocator with coalescing: stream ports, output register, config.
// Depends on ffba_pkg and ffba_engine.
//
// Usage: commands enter on the s_ channel (s_tuser = cmd: 0 allocate, 1 free;
// s_tdata = request_bytes, free_offset). Each command yields exactly one
// transaction on the m_ channel (m_tdata = data_offset, m_tuser = status).
// The heap size is written over cfg_valid/cfg_ready/cfg_data while idle; it
// rebuilds the heap as one free block.
// An allocate checks the free blocks in turn (the next header read overlaps the
// test), then passes the in-use blocks while linking the block in. A free
// passes the in-use blocks in the lookup and the free blocks while linking,
// then merges with the block below and with the block above where they adjoin.
// A null free or an allocate on an empty free list answers without a walk.
// One command is processed at a time.
// Reset: header 0 is written in the first cycle after reset, which leaves a
// heap of min(4096, HEAP_BYTES) bytes with an empty in-use list.
// Stall: the result sits in an output register; the next command is accepted
// while it waits, and the engine holds a second result until the register
// frees up.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES   = DEF_HEAP_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [12:0] request_bytes, [25:13] free_offset
    input  logic               s_tuser,   // [0] cmd
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [12:0] data_offset
    output logic [1:0]         m_tuser,   // [1:0] status
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data
);

    logic eng_idle;
    logic eng_start;
    logic res_valid;
    logic res_ready;
    req_t req;
    res_t eng_res;

    logic m_valid_reg, m_valid_next;
    res_t m_res_reg,   m_res_next;

    // Configuration takes precedence over a command in the same cycle
    assign cfg_ready = eng_idle;
    assign s_tready  = eng_idle & ~cfg_valid;
    assign eng_start = s_tvalid & s_tready;

    assign req = '{cmd:           s_tuser,
                   request_bytes: s_tdata[12:0],
                   free_offset:   s_tdata[25:13]};

    ffba_engine #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .req       (req),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .idle      (eng_idle),
        .res_valid (res_valid),
        .res       (eng_res),
        .res_ready (res_ready)
    );

    // Output register: load when empty or being drained
    assign res_ready = ~m_valid_reg | m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = eng_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.data_offset};
    assign m_tuser  = m_res_reg.status;

`ifndef SYNTH
    // Commands are never accepted back to back
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted back to back");

    // Both ports are not ready in the cycle after a heap size write, while the heap is rebuilt
    a_busy_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !cfg_ready && !s_tready)
        else $error("port ready during heap rebuild");

    // Failed commands carry a zero offset
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NO_FIT || m_tuser == ST_BAD_FREE) |-> m_tdata == 16'd0)
        else $error("nonzero offset on failed command");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for first_fit_block_allocator: drives allocate and free
// commands, predicts each answer with a heap model of its own. Depends on ffba_pkg.
module testbench;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP  = DEF_HEAP_BYTES;
    localparam int HDR   = DEF_HEADER_BYTES;
    localparam int NIL   = HEAP;
    localparam int QUIET_LIMIT = 10000;

    logic aclk, aresetn;
    logic s_tvalid, s_tready, s_tuser;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_valid, cfg_ready;
    logic [FIELD_W-1:0] cfg_data;

    first_fit_block_allocator dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Heap model state
    int blk_size [HEAP];
    int blk_next [HEAP];
    int free_head, used_head;
    int live_ptrs[$];
    res_t answers_due[$];
    int send_idle_pct, recv_stall_pct;
    int quiet_cycles = 0;
    bit failed = 1'b0;

    function automatic void heap_init(int v);
        if (v < HDR) v = HDR;
        if (v > HEAP) v = HEAP;
        blk_size[0] = v - HDR;
        blk_next[0] = NIL;
        free_head = 0;
        used_head = NIL;
        live_ptrs.delete();
    endfunction

    function automatic int sz(int o);
        return o < NIL ? blk_size[o] : 0;
    endfunction

    function automatic int nxt(int o);
        return o < NIL ? blk_next[o] : NIL;
    endfunction

    // Link blk into the ordered list; return its predecessor or NIL
    function automatic int link_sorted(ref int head, input int blk);
        int prev, p;
        prev = NIL;
        p = head;
        while (p < NIL && p <= blk) begin
            prev = p;
            p = nxt(p);
        end
        if (blk < NIL) blk_next[blk] = p;
        if (prev == NIL) head = blk;
        else blk_next[prev] = blk;
        return prev;
    endfunction

    function automatic res_t heap_alloc(int req);
        int prev, cur, s, rest, dummy;
        res_t r;
        prev = NIL;
        cur = free_head;
        while (cur < NIL) begin
            s = sz(cur);
            if (s >= req) begin
                if (s >= req + HDR) begin
                    rest = cur + HDR + req;
                    if (rest < NIL) begin
                        blk_size[rest] = s - HDR - req;
                        blk_next[rest] = nxt(cur);
                    end
                    blk_size[cur] = req;
                end else begin
                    rest = nxt(cur);
                end
                if (prev == NIL) free_head = rest;
                else blk_next[prev] = rest;
                dummy = link_sorted(used_head, cur);
                r.data_offset = FIELD_W'(cur + HDR);
                r.status = ST_OK;
                live_ptrs.push_back(cur + HDR);
                return r;
            end
            prev = cur;
            cur = nxt(cur);
        end
        r.data_offset = '0;
        r.status = ST_NO_FIT;
        return r;
    endfunction

    function automatic res_t heap_release(int ptr);
        int prev, cur, left, nx;
        res_t r;
        r.data_offset = '0;
        r.status = ST_BAD_FREE;
        if (ptr == 0) return r;
        prev = NIL;
        cur = used_head;
        forever begin
            if (cur >= NIL || cur + HDR > ptr) return r;
            if (cur + HDR == ptr) break;
            prev = cur;
            cur = nxt(cur);
        end
        if (prev == NIL) used_head = nxt(cur);
        else blk_next[prev] = nxt(cur);
        foreach (live_ptrs[i])
            if (live_ptrs[i] == ptr) begin
                live_ptrs.delete(i);
                break;
            end
        left = link_sorted(free_head, cur);
        // Merge with the block below, then with the one above
        if (left != NIL && left + HDR + sz(left) == cur) begin
            blk_size[left] = sz(left) + HDR + sz(cur);
            blk_next[left] = nxt(cur);
            cur = left;
        end
        nx = nxt(cur);
        if (nx < NIL && cur + HDR + sz(cur) == nx) begin
            blk_size[cur] = sz(cur) + HDR + sz(nx);
            blk_next[cur] = nxt(nx);
        end
        r.status = ST_OK;
        return r;
    endfunction

    // Send one command and queue its predicted answer; tvalid drops only when idling
    task automatic send_cmd(logic cmd, int req, int ptr);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, FIELD_W'(ptr), FIELD_W'(req)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        answers_due.push_back(cmd == CMD_ALLOC ? heap_alloc(req) : heap_release(ptr));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (600) @(negedge aclk);
    endtask

    // Write the heap size while idle
    task automatic write_heap_size(int v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= FIELD_W'(v);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        heap_init(v & 13'h1FFF);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Check each answer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $error("unexpected answer offset=%0d status=%0d", m_tdata[12:0], m_tuser);
                failed = 1'b1;
            end else begin
                res_t e;
                e = answers_due.pop_front();
                if (m_tdata[12:0] !== e.data_offset) begin
                    $error("data_offset: expected %0d, got %0d", e.data_offset, m_tdata[12:0]);
                    failed = 1'b1;
                end
                if (m_tuser !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // Randomize receiver stalls
    always @(negedge aclk)
        m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    // Watchdog: count cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic int pick_ptr();
        if (live_ptrs.size() != 0 && $urandom_range(9) < 8)
            return live_ptrs[$urandom_range(live_ptrs.size() - 1)];
        return $urandom_range(8191);
    endfunction

    task automatic test_directed_alloc_free();
        int p;
        send_cmd(CMD_ALLOC, 0, 0);            // zero-byte request
        send_cmd(CMD_ALLOC, 100, 0);
        send_cmd(CMD_ALLOC, 8191, 0);         // no fit
        send_cmd(CMD_ALLOC, HEAP - 3 * HDR - 100, 0);
        send_cmd(CMD_FREE, 0, 0);             // null pointer
        send_cmd(CMD_FREE, 0, 8191);          // unknown
        send_cmd(CMD_FREE, 0, 5);
        p = HDR;
        send_cmd(CMD_FREE, 0, p + HDR);       // frees the 100-byte block
        send_cmd(CMD_FREE, 0, HDR);           // merges with right
        send_cmd(CMD_FREE, 0, HDR);           // now unknown
        send_cmd(CMD_ALLOC, 4080, 0);
        send_cmd(CMD_ALLOC, 116, 0);
    endtask

    task automatic test_heap_size_extremes();
        write_heap_size(0);                   // clamped up: one zero-size block
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, 0, 0);
        send_cmd(CMD_ALLOC, 0, 0);
        send_cmd(CMD_FREE, 0, HDR);
        write_heap_size(8191);                // clamped down
        send_cmd(CMD_ALLOC, 4080, 0);
        send_cmd(CMD_FREE, 0, HDR);
        write_heap_size(HDR + 20);
        send_cmd(CMD_ALLOC, 10, 0);           // remainder too small to split
        send_cmd(CMD_ALLOC, 0, 0);
    endtask

    task automatic run_random(int n, int hsize);
        write_heap_size(hsize);
        repeat (n) begin
            if ($urandom_range(99) < 55)
                send_cmd(CMD_ALLOC, $urandom_range(9) == 0 ? $urandom_range(8191)
                                                        : $urandom_range(hsize / 6), 0);
            else
                send_cmd(CMD_FREE, $urandom_range(8191), pick_ptr());
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  recv_stall_pct = 0;  run_random(380, 4096);
        send_idle_pct = 50; recv_stall_pct = 0;  run_random(380, 1024);
        send_idle_pct = 0;  recv_stall_pct = 50; run_random(380, 512);
        send_idle_pct = 18; recv_stall_pct = 18; run_random(380, 16 + $urandom_range(4080));
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        heap_init(HEAP);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);
        test_directed_alloc_free();
        test_heap_size_extremes();
        test_random_phases();
        drain();
        if (!failed && answers_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

FILE: files.f
hdl/ffba_pkg.sv
hdl/ffba_engine.sv
hdl/first_fit_block_allocator.sv
tb/testbench.sv
